/* rtl/cmld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cmld_pkg;

   localparam int RING_DEPTH  = 256;
   localparam int LINE_DEPTH  = 256;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int RING_CW     = $clog2(RING_DEPTH + 1);
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   localparam int LINE_CW     = $clog2(LINE_DEPTH + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // request codes
   localparam logic [1:0] REQ_PUSH   = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_DATA   = 3'd0;
   localparam logic [2:0] KIND_NODATA = 3'd1;
   localparam logic [2:0] KIND_EOF    = 3'd2;
   localparam logic [2:0] KIND_ECHO   = 3'd3;
   localparam logic [2:0] KIND_AVAIL  = 3'd4;

   // register indexes
   localparam logic CSR_RAW_MODE    = 1'b0;
   localparam logic CSR_ECHO_ENABLE = 1'b1;

   // pending signal codes
   localparam logic [1:0] SIG_NONE    = 2'd0;
   localparam logic [1:0] SIG_INT     = 2'd1;
   localparam logic [1:0] SIG_SUSPEND = 2'd2;

   // character codes
   localparam logic [7:0] CH_EOT   = 8'd4;
   localparam logic [7:0] CH_ETX   = 8'd3;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SUB   = 8'd26;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL   = 8'd127;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] in_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic raw_mode;
      logic echo_enable;
   } csr_regs_type;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_INTR,
      OP_SUSPEND,
      OP_READ,
      OP_QUERY
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       term;
   } cmd_type;

   function automatic logic is_term(input logic [7:0] b);
      return (b == CH_LF) || (b == CH_CR) || (b == CH_EOT);
   endfunction

endpackage

`default_nettype wire

/* rtl/cmld_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/cmld_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmld_front
   import cmld_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire csr_regs_type    csr_regs,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 q_valid,
   input  wire logic            q_ready,
   output cmd_type              q_cmd
);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] cnt_ff, cnt_in;
   cmd_type             cmd;
   logic                enq;
   logic                deq;

   // classify: signal characters are caught here in cooked mode
   always_comb begin
      cmd.data = req_payload.in_byte;
      cmd.term = is_term(req_payload.in_byte);
      cmd.op   = OP_PUSH;
      case (req_payload.req_type)
         REQ_PUSH: begin
            if (!csr_regs.raw_mode && req_payload.in_byte == CH_ETX) begin
               cmd.op = OP_INTR;
            end else if (!csr_regs.raw_mode && req_payload.in_byte == CH_SUB) begin
               cmd.op = OP_SUSPEND;
            end else begin
               cmd.op = OP_PUSH;
            end
         end
         REQ_READ:  cmd.op = OP_READ;
         REQ_QUERY: cmd.op = OP_QUERY;
         default:   cmd.op = OP_PUSH;
      endcase
   end

   assign req_ready = (cnt_ff != QUEUE_CW'(QUEUE_DEPTH));
   // unused request code is taken and dropped
   assign enq = req_valid && req_ready
             && (req_payload.req_type == REQ_PUSH || req_payload.req_type == REQ_READ
                 || req_payload.req_type == REQ_QUERY);
   assign q_valid = (cnt_ff != '0);
   assign q_cmd   = queue_ff[rd_ptr_ff];
   assign deq     = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq && !deq) begin
         cnt_in = cnt_ff + QUEUE_CW'(1);
      end else if (!enq && deq) begin
         cnt_in = cnt_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cmld_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module cmld_back
   import cmld_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire csr_regs_type csr_regs,
   input  wire logic         q_valid,
   output logic              q_ready,
   input  wire cmd_type      q_cmd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_payload_type   rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RAW,
      ST_COOK,
      ST_ECHO,
      ST_LINE_RD,
      ST_LINE_OUT
   } state_type;

   typedef enum logic [1:0] {
      TAIL_NODATA,
      TAIL_EOF,
      TAIL_DELIVER
   } tail_type;

   function automatic logic [RING_AW-1:0] ring_wrap(input logic [RING_AW-1:0] p);
      logic [RING_CW-1:0] nxt;
      nxt = RING_CW'(p) + RING_CW'(1);
      if (nxt == RING_CW'(RING_DEPTH)) begin
         return '0;
      end
      return nxt[RING_AW-1:0];
   endfunction

   state_type       state_ff, state_in;
   logic [RING_AW-1:0] head_ff, head_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [RING_CW-1:0] count_ff, count_in;
   logic [RING_CW-1:0] term_cnt_ff, term_cnt_in;
   logic [LINE_CW-1:0] len_ff, len_in;
   logic [LINE_CW-1:0] rpos_ff, rpos_in;
   logic               complete_ff, complete_in;
   logic [1:0]         pending_ff, pending_in;
   logic [23:0]        echo_bytes_ff, echo_bytes_in;
   logic [1:0]         echo_cnt_ff, echo_cnt_in;
   tail_type           tail_kind_ff, tail_kind_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               ring_wr_en, ring_rd_en;
   logic [7:0]         ring_rd_data;
   logic               line_wr_en, line_rd_en;
   logic [LINE_AW-1:0] line_wr_addr;
   logic [7:0]         line_wr_data;
   logic [7:0]         line_rd_data;

   logic               can_emit;
   logic [LINE_CW-1:0] rpos_inc;
   logic               avail;
   logic               line_ready;

   cmld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (tail_ff),
      .wr_data (q_cmd.data),
      .rd_en   (ring_rd_en),
      .rd_addr (head_ff),
      .rd_data (ring_rd_data)
   );

   cmld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_en   (line_rd_en),
      .rd_addr (rpos_ff[LINE_AW-1:0]),
      .rd_data (line_rd_data)
   );

   assign can_emit   = !rsp_valid_ff || rsp_ready;
   assign rpos_inc   = rpos_ff + LINE_CW'(1);
   assign line_ready = complete_ff && (rpos_ff < len_ff);
   assign avail      = csr_regs.raw_mode ? (count_ff != '0)
                                         : (line_ready || term_cnt_ff != '0);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      term_cnt_in    = term_cnt_ff;
      len_in         = len_ff;
      rpos_in        = rpos_ff;
      complete_in    = complete_ff;
      pending_in     = pending_ff;
      echo_bytes_in  = echo_bytes_ff;
      echo_cnt_in    = echo_cnt_ff;
      tail_kind_in   = tail_kind_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      q_ready        = 1'b0;
      ring_wr_en     = 1'b0;
      ring_rd_en     = 1'b0;
      line_wr_en     = 1'b0;
      line_rd_en     = 1'b0;
      line_wr_addr   = len_ff[LINE_AW-1:0];
      line_wr_data   = ring_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_PUSH: begin
                     q_ready = 1'b1;
                     if (count_ff != RING_CW'(RING_DEPTH)) begin
                        ring_wr_en = 1'b1;
                        tail_in    = ring_wrap(tail_ff);
                        count_in   = count_ff + RING_CW'(1);
                        if (q_cmd.term) begin
                           term_cnt_in = term_cnt_ff + RING_CW'(1);
                        end
                     end
                  end
                  OP_INTR: begin
                     q_ready    = 1'b1;
                     pending_in = SIG_INT;
                  end
                  OP_SUSPEND: begin
                     q_ready    = 1'b1;
                     pending_in = SIG_SUSPEND;
                  end
                  OP_QUERY: begin
                     if (can_emit) begin
                        q_ready        = 1'b1;
                        rsp_valid_in   = 1'b1;
                        rsp_payload_in = '{kind: KIND_AVAIL, out_byte: {7'd0, avail},
                                           last: 1'b1};
                     end
                  end
                  OP_READ: begin
                     if (pending_ff == SIG_INT || pending_ff == SIG_SUSPEND) begin
                        if (can_emit) begin
                           q_ready        = 1'b1;
                           pending_in     = SIG_NONE;
                           rsp_valid_in   = 1'b1;
                           rsp_payload_in = '{kind: KIND_DATA,
                                              out_byte: (pending_ff == SIG_INT) ? CH_ETX
                                                                                : CH_SUB,
                                              last: 1'b1};
                        end
                     end else begin
                        pending_in = SIG_NONE;
                        if (!csr_regs.raw_mode && line_ready) begin
                           q_ready    = 1'b1;
                           line_rd_en = 1'b1;
                           rpos_in    = rpos_inc;
                           if (rpos_inc >= len_ff) begin
                              len_in      = '0;
                              rpos_in     = '0;
                              complete_in = 1'b0;
                           end
                           state_in = ST_LINE_OUT;
                        end else begin
                           // a drained line is dropped before editing resumes
                           if (!csr_regs.raw_mode && complete_ff) begin
                              len_in      = '0;
                              rpos_in     = '0;
                              complete_in = 1'b0;
                           end
                           if (count_ff == '0) begin
                              if (can_emit) begin
                                 q_ready        = 1'b1;
                                 rsp_valid_in   = 1'b1;
                                 rsp_payload_in = '{kind: KIND_NODATA, out_byte: 8'd0,
                                                    last: 1'b1};
                              end
                           end else begin
                              q_ready    = 1'b1;
                              ring_rd_en = 1'b1;
                              head_in    = ring_wrap(head_ff);
                              count_in   = count_ff - RING_CW'(1);
                              state_in   = csr_regs.raw_mode ? ST_RAW : ST_COOK;
                           end
                        end
                     end
                  end
                  default: q_ready = 1'b1;
               endcase
            end
         end

         ST_RAW: begin
            if (can_emit) begin
               if (is_term(ring_rd_data) && term_cnt_ff != '0) begin
                  term_cnt_in = term_cnt_ff - RING_CW'(1);
               end
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{kind: KIND_DATA, out_byte: ring_rd_data, last: 1'b1};
               state_in       = ST_IDLE;
            end
         end

         ST_COOK: begin
            if (is_term(ring_rd_data) && term_cnt_ff != '0) begin
               term_cnt_in = term_cnt_ff - RING_CW'(1);
            end
            echo_cnt_in  = 2'd0;
            tail_kind_in = TAIL_NODATA;
            if (ring_rd_data == CH_BS || ring_rd_data == CH_DEL) begin
               if (len_ff != '0) begin
                  len_in = len_ff - LINE_CW'(1);
                  if (csr_regs.echo_enable) begin
                     echo_bytes_in = {CH_BS, CH_SPACE, CH_BS};
                     echo_cnt_in   = 2'd3;
                  end
               end
            end else if (ring_rd_data == CH_LF || ring_rd_data == CH_CR) begin
               if (len_ff < LINE_CW'(LINE_DEPTH)) begin
                  line_wr_en = 1'b1;
                  len_in     = len_ff + LINE_CW'(1);
               end
               if (csr_regs.echo_enable) begin
                  echo_bytes_in = {CH_CR, CH_LF, 8'd0};
                  echo_cnt_in   = 2'd2;
               end
               complete_in  = 1'b1;
               rpos_in      = '0;
               tail_kind_in = TAIL_DELIVER;
            end else if (ring_rd_data == CH_EOT) begin
               if (len_ff == '0) begin
                  tail_kind_in = TAIL_EOF;
               end else begin
                  complete_in  = 1'b1;
                  rpos_in      = '0;
                  tail_kind_in = TAIL_DELIVER;
               end
            end else if (ring_rd_data == CH_ESC) begin
               tail_kind_in = TAIL_NODATA;
            end else begin
               if (len_ff < LINE_CW'(LINE_DEPTH)) begin
                  line_wr_en = 1'b1;
                  len_in     = len_ff + LINE_CW'(1);
                  if (csr_regs.echo_enable) begin
                     echo_bytes_in = {ring_rd_data, 16'd0};
                     echo_cnt_in   = 2'd1;
                  end
               end
            end
            state_in = ST_ECHO;
         end

         ST_ECHO: begin
            if (echo_cnt_ff != 2'd0) begin
               if (can_emit) begin
                  rsp_valid_in   = 1'b1;
                  rsp_payload_in = '{kind: KIND_ECHO, out_byte: echo_bytes_ff[23:16],
                                     last: 1'b0};
                  echo_bytes_in  = {echo_bytes_ff[15:0], 8'd0};
                  echo_cnt_in    = echo_cnt_ff - 2'd1;
               end
            end else begin
               case (tail_kind_ff)
                  TAIL_DELIVER: state_in = ST_LINE_RD;
                  TAIL_EOF: begin
                     if (can_emit) begin
                        rsp_valid_in   = 1'b1;
                        rsp_payload_in = '{kind: KIND_EOF, out_byte: 8'd0, last: 1'b1};
                        state_in       = ST_IDLE;
                     end
                  end
                  default: begin
                     if (can_emit) begin
                        rsp_valid_in   = 1'b1;
                        rsp_payload_in = '{kind: KIND_NODATA, out_byte: 8'd0, last: 1'b1};
                        state_in       = ST_IDLE;
                     end
                  end
               endcase
            end
         end

         ST_LINE_RD: begin
            line_rd_en = 1'b1;
            rpos_in    = rpos_inc;
            if (rpos_inc >= len_ff) begin
               len_in      = '0;
               rpos_in     = '0;
               complete_in = 1'b0;
            end
            state_in = ST_LINE_OUT;
         end

         ST_LINE_OUT: begin
            if (can_emit) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = '{kind: KIND_DATA, out_byte: line_rd_data, last: 1'b1};
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      echo_bytes_ff  <= echo_bytes_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         term_cnt_ff  <= '0;
         len_ff       <= '0;
         rpos_ff      <= '0;
         complete_ff  <= 1'b0;
         pending_ff   <= SIG_NONE;
         echo_cnt_ff  <= 2'd0;
         tail_kind_ff <= TAIL_NODATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         term_cnt_ff  <= term_cnt_in;
         len_ff       <= len_in;
         rpos_ff      <= rpos_in;
         complete_ff  <= complete_in;
         pending_ff   <= pending_in;
         echo_cnt_ff  <= echo_cnt_in;
         tail_kind_ff <= tail_kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* rtl/cooked_mode_line_discipline_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                                       direction
// req       req_valid req_ready req_payload             in:  push, read, query
// rsp       rsp_valid rsp_ready rsp_payload             out: data, echo, status
// csr       csr_valid csr_ready csr_index csr_wdata     in:  raw_mode, echo_enable
//
// requests enter a 4-deep command queue at one per cycle while it has room.
// the executor takes a push or signal without a result; unused codes are dropped.
// a query, signal read or empty-ring read answers from state; a raw read uses the
// ring ram; a cooked read: ring ram read, edit, up to 3 echoes, line ram read.
// synchronous reset empties ring, line and queue; no clearing pass is needed.
// a stalled rsp holds the executor; the queue keeps taking requests meanwhile.

module cooked_mode_line_discipline_core
   import cmld_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic            csr_index,
   input  wire logic            csr_wdata
);

   logic         raw_mode_ff;
   logic         echo_enable_ff;
   csr_regs_type csr_regs;
   logic         q_valid;
   logic         q_ready;
   cmd_type      q_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff    <= 1'b0;
         echo_enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RAW_MODE:    raw_mode_ff    <= csr_wdata;
            CSR_ECHO_ENABLE: echo_enable_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_regs = '{raw_mode: raw_mode_ff, echo_enable: echo_enable_ff};

   cmld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_regs    (csr_regs),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_cmd       (q_cmd)
   );

   cmld_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_regs    (csr_regs),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_cmd       (q_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import cmld_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS = 6;

   // tracks ring, line and signal state; holds the results each transaction is owed
   class cooked_line_predictor;
      logic [7:0] rx_bytes [RING_DEPTH];
      logic [7:0] line_bytes [LINE_DEPTH];
      int unsigned rd_idx, wr_idx, held, held_ends;
      int unsigned line_len, line_pos;
      bit line_ready;
      logic [1:0] sig;
      bit raw, echo;
      rsp_payload_type due[$];
      rsp_payload_type batch[$];
      int errors;

      function new();
         rd_idx = 0;
         wr_idx = 0;
         held = 0;
         held_ends = 0;
         line_len = 0;
         line_pos = 0;
         line_ready = 0;
         sig = SIG_NONE;
         raw = 0;
         echo = 1;
         errors = 0;
      endfunction

      function bit ends_line(logic [7:0] b);
         return b == CH_LF || b == CH_CR || b == CH_EOT;
      endfunction

      function void put(logic [2:0] k, logic [7:0] b);
         rsp_payload_type r;
         r.kind = k;
         r.out_byte = b;
         r.last = 1'b0;
         batch.push_back(r);
      endfunction

      function bit pop_byte(output logic [7:0] b);
         if (held == 0) return 0;
         b = rx_bytes[rd_idx];
         rd_idx = (rd_idx + 1) % RING_DEPTH;
         held--;
         if (ends_line(b) && held_ends > 0) held_ends--;
         return 1;
      endfunction

      function void drop_line();
         line_len = 0;
         line_pos = 0;
         line_ready = 0;
      endfunction

      function void hand_out();
         logic [7:0] b;
         b = line_bytes[line_pos % LINE_DEPTH];
         line_pos++;
         if (line_pos >= line_len) drop_line();
         put(KIND_DATA, b);
      endfunction

      function void finish_line();
         line_ready = 1;
         line_pos = 0;
         hand_out();
      endfunction

      function void edit_step();
         logic [7:0] b;
         if (line_ready) begin
            if (line_pos < line_len && line_pos < LINE_DEPTH) begin
               hand_out();
               return;
            end
            drop_line();
         end
         if (!pop_byte(b)) begin
            put(KIND_NODATA, 8'd0);
            return;
         end
         case (b)
            CH_BS, CH_DEL: begin
               if (line_len > 0) begin
                  line_len--;
                  if (echo) begin
                     put(KIND_ECHO, CH_BS);
                     put(KIND_ECHO, CH_SPACE);
                     put(KIND_ECHO, CH_BS);
                  end
               end
               put(KIND_NODATA, 8'd0);
            end
            CH_LF, CH_CR: begin
               if (line_len < LINE_DEPTH) begin
                  line_bytes[line_len] = b;
                  line_len++;
               end
               if (echo) begin
                  put(KIND_ECHO, CH_CR);
                  put(KIND_ECHO, CH_LF);
               end
               finish_line();
            end
            CH_EOT: begin
               if (line_len == 0) put(KIND_EOF, 8'd0);
               else finish_line();
            end
            CH_ESC: put(KIND_NODATA, 8'd0);
            default: begin
               if (line_len < LINE_DEPTH) begin
                  line_bytes[line_len] = b;
                  line_len++;
                  if (echo) put(KIND_ECHO, b);
               end
               put(KIND_NODATA, 8'd0);
            end
         endcase
      endfunction

      function void set_reg(logic idx, logic val);
         if (idx == CSR_RAW_MODE) raw = val;
         else echo = val;
      endfunction

      function void take_request(req_payload_type p);
         logic [7:0] b;
         bit avail;
         rsp_payload_type r;
         batch.delete();
         case (p.req_type)
            REQ_PUSH: begin
               if (!raw && p.in_byte == CH_ETX) sig = SIG_INT;
               else if (!raw && p.in_byte == CH_SUB) sig = SIG_SUSPEND;
               else if (held < RING_DEPTH) begin
                  rx_bytes[wr_idx] = p.in_byte;
                  wr_idx = (wr_idx + 1) % RING_DEPTH;
                  held++;
                  if (ends_line(p.in_byte)) held_ends++;
               end
            end
            REQ_READ: begin
               if (sig == SIG_INT || sig == SIG_SUSPEND) begin
                  put(KIND_DATA, (sig == SIG_INT) ? CH_ETX : CH_SUB);
                  sig = SIG_NONE;
               end else begin
                  sig = SIG_NONE;
                  if (raw) begin
                     if (pop_byte(b)) put(KIND_DATA, b);
                     else put(KIND_NODATA, 8'd0);
                  end else begin
                     edit_step();
                  end
               end
            end
            REQ_QUERY: begin
               if (raw) avail = held > 0;
               else avail = (line_ready && line_pos < line_len) || held_ends > 0;
               put(KIND_AVAIL, {7'd0, avail});
            end
            default: ;
         endcase
         if (batch.size() > 0) begin
            r = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
         end
         foreach (batch[i]) due.push_back(batch[i]);
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= 10) $display("mismatch: %s", msg);
      endfunction

      function void match_result(rsp_payload_type got);
         rsp_payload_type want;
         if (due.size() == 0) begin
            note_error($sformatf("unexpected result kind=%0d byte=%0d last=%0d",
                                 got.kind, got.out_byte, got.last));
            return;
         end
         want = due.pop_front();
         if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
             got.last !== want.last)
            note_error($sformatf("expected kind=%0d byte=%0d last=%0d, %s",
                                 want.kind, want.out_byte, want.last,
                                 $sformatf("got kind=%0d byte=%0d last=%0d",
                                           got.kind, got.out_byte, got.last)));
      endfunction

      function void close_out();
         if (due.size() != 0)
            note_error($sformatf("%0d results never arrived", due.size()));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_RAW_MODE;
   logic csr_wdata = 1'b0;

   int gap_pct = 0;
   int stall_pct = 0;
   int sent = 0;

   cooked_line_predictor pred = new();

   cooked_mode_line_discipline_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // result is checked before the new transaction's results are queued
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) pred.set_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) pred.match_result(rsp_payload);
         if (req_valid && req_ready) pred.take_request(req_payload);
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [7:0] data);
      req_payload_type p;
      int gap;
      p.req_type = op;
      p.in_byte = data;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != REQ_UNUSED) sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pred.due.size() != 0) @(posedge clock);
      // pushes give no result but may still sit in the command queue
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_modes(input logic raw, input logic echo);
      csr_valid <= 1'b1;
      csr_index <= CSR_RAW_MODE;
      csr_wdata <= raw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_ECHO_ENABLE;
      csr_wdata <= echo;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 8'($urandom_range(8'h20, 8'h7e));
      if (r < 75) return $urandom_range(1) ? CH_BS : CH_DEL;
      if (r < 79) return CH_ESC;
      if (r < 83) return $urandom_range(1) ? CH_ETX : CH_SUB;
      return 8'($urandom_range(255));
   endfunction

   // one typed line, reads sprinkled in, then enough reads to drain it
   task automatic type_line();
      int n;
      int reads;
      logic [7:0] ender;
      n = $urandom_range(0, 5);
      reads = 0;
      repeat (n) begin
         if ($urandom_range(3) == 0) begin
            send_item(REQ_READ, 8'($urandom_range(255)));
            reads++;
         end
         send_item(REQ_PUSH, pick_char());
      end
      case ($urandom_range(2))
         0: ender = CH_LF;
         1: ender = CH_CR;
         default: ender = CH_EOT;
      endcase
      send_item(REQ_PUSH, ender);
      repeat (2 * n + 2 - reads + $urandom_range(0, 2)) begin
         if ($urandom_range(5) == 0) send_item(REQ_QUERY, 8'($urandom_range(255)));
         send_item(REQ_READ, 8'($urandom_range(255)));
      end
   endtask

   // empty ring and line, overflow the ring, overflow the line, then end the line
   task automatic fill_line();
      send_item(REQ_PUSH, CH_CR);
      do send_item(REQ_READ, 8'd0);
      while (pred.held > 0 || pred.line_ready);
      repeat (RING_DEPTH + 2) send_item(REQ_PUSH, 8'h61 + 8'($urandom_range(25)));
      send_item(REQ_QUERY, 8'd0);
      repeat (RING_DEPTH) send_item(REQ_READ, 8'd0);
      repeat (2) begin
         send_item(REQ_PUSH, 8'h41 + 8'($urandom_range(25)));
         send_item(REQ_READ, 8'd0);
      end
      send_item(REQ_PUSH, CH_CR);
      send_item(REQ_QUERY, 8'd0);
      repeat (3) send_item(REQ_READ, 8'd0);
   endtask

   initial begin
      bit phase_raw [8];
      bit phase_echo [8];
      int goal;
      phase_raw = '{0, 0, 1, 0, 1, 0, 0, 1};
      phase_echo = '{1, 0, 1, 1, 0, 1, 0, 1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset modes are cooked with echo
      send_item(REQ_READ, 8'hff);
      send_item(REQ_QUERY, 8'h00);
      send_item(REQ_PUSH, CH_ETX);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_PUSH, CH_SUB);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_PUSH, 8'h68);
      send_item(REQ_PUSH, 8'hff);
      send_item(REQ_PUSH, CH_BS);
      send_item(REQ_PUSH, CH_ESC);
      send_item(REQ_PUSH, CH_DEL);
      send_item(REQ_PUSH, CH_CR);
      send_item(REQ_QUERY, 8'hff);
      repeat (6) send_item(REQ_READ, 8'h00);
      send_item(REQ_PUSH, CH_EOT);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_PUSH, 8'h00);
      send_item(REQ_PUSH, CH_EOT);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_UNUSED, 8'hff);
      send_item(REQ_READ, 8'h00);

      for (int ph = 0; ph < 8; ph++) begin
         wait_drained();
         set_modes(phase_raw[ph], phase_echo[ph]);
         case (ph % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 52; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 52; end
            default: begin gap_pct = 8; stall_pct = 8; end
         endcase
         goal = sent + PHASE_ITEMS;
         while (sent < goal) begin
            if ($urandom_range(99) < 80) type_line();
            else repeat ($urandom_range(1, 6))
               send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
         end
      end

      wait_drained();
      set_modes(1'b0, 1'b1);
      fill_line();

      req_valid <= 1'b0;
      for (int i = 0; i < 20000 && pred.due.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      pred.close_out();
      if (pred.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
